// ----- src/b2y_pkg.sv -----
`default_nettype none

package b2y_pkg;

   // line store and position counters
   localparam int MAX_LINE   = 4096;
   localparam int COL_W      = $clog2(MAX_LINE);
   localparam int HEIGHT_CAP = 4096;
   localparam int ROW_W      = $clog2(HEIGHT_CAP);

   // configuration port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 13;
   localparam logic [CSR_INDEX_W-1:0] CSR_LINE_WIDTH   = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_FRAME_HEIGHT = 1'd1;
   localparam logic [CSR_DATA_W-1:0]  LINE_WIDTH_RESET   = 13'd640;
   localparam logic [CSR_DATA_W-1:0]  FRAME_HEIGHT_RESET = 13'd480;
   localparam logic [CSR_DATA_W-1:0]  MIN_DIM      = 13'd2;
   localparam logic [CSR_DATA_W-1:0]  WIDTH_LIMIT  = CSR_DATA_W'(MAX_LINE - (MAX_LINE % 2));
   localparam logic [CSR_DATA_W-1:0]  HEIGHT_LIMIT = CSR_DATA_W'(HEIGHT_CAP);

   // fixed-point coefficients
   localparam int FRAC_W       = 15;
   localparam int LUMA_SUM_W   = 23;
   localparam int CHROMA_SUM_W = 25;
   localparam logic [LUMA_SUM_W-1:0] LUMA_R_COEF = 23'd9798;
   localparam logic [LUMA_SUM_W-1:0] LUMA_G_COEF = 23'd19235;
   localparam logic [LUMA_SUM_W-1:0] LUMA_B_COEF = 23'd3736;
   localparam logic signed [15:0] CB_R_COEF = -16'sd5538;
   localparam logic signed [15:0] CB_G_COEF = -16'sd10846;
   localparam logic signed [15:0] CB_B_COEF = 16'sd16351;
   localparam logic signed [15:0] CR_R_COEF = 16'sd16351;
   localparam logic signed [15:0] CR_G_COEF = -16'sd13697;
   localparam logic signed [15:0] CR_B_COEF = -16'sd2664;
   localparam logic signed [CHROMA_SUM_W-1:0] CHROMA_OFFSET =
      CHROMA_SUM_W'(128 << FRAC_W);

   // queues
   localparam int MIDQ_DEPTH = 4;
   localparam int MIDQ_PTR_W = $clog2(MIDQ_DEPTH);
   localparam int MIDQ_CNT_W = $clog2(MIDQ_DEPTH + 1);
   localparam int OUTQ_DEPTH = 8;
   localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
   localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

   typedef struct packed {
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } req_word_type;

   typedef struct packed {
      logic [7:0] luma;
      logic       chroma_valid;
      logic [7:0] cb;
      logic [7:0] cr;
   } rsp_word_type;

   typedef struct packed {
      req_word_type pixel;
      req_word_type left_pixel;
      req_word_type upper_left;
      req_word_type upper_right;
      logic         chroma_en;
   } midq_entry_type;

   typedef struct packed {
      logic                  not_empty;
      logic [MIDQ_CNT_W-1:0] count;
   } midq_status_type;

endpackage

`default_nettype wire

// ----- src/b2y_front.sv -----
`default_nettype none

module b2y_front (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           push,
   output logic                                full,
   input  wire b2y_pkg::req_word_type          req_word,
   input  wire logic [b2y_pkg::CSR_DATA_W-1:0] line_width,
   input  wire logic [b2y_pkg::CSR_DATA_W-1:0] frame_height,
   input  wire b2y_pkg::midq_status_type       midq_status,
   output logic                                midq_push,
   output b2y_pkg::midq_entry_type             midq_entry
);

   b2y_pkg::req_word_type store_mem [b2y_pkg::MAX_LINE];

   logic [b2y_pkg::COL_W-1:0]      col_ff, col_in;
   logic [b2y_pkg::ROW_W-1:0]      row_ff, row_in;
   b2y_pkg::req_word_type          left_ff;
   logic                           f1_valid_ff;
   b2y_pkg::req_word_type          f1_pixel_ff, f1_left_ff, f1_ul_ff, f1_ur_ff;
   logic                           f1_chroma_ff;
   logic                           accept;
   logic [b2y_pkg::CSR_DATA_W-1:0] width_eff, height_eff, width_even, height_even;
   logic [b2y_pkg::COL_W:0]        col_inc;
   logic [b2y_pkg::ROW_W:0]        row_inc;

   assign full   = (b2y_pkg::MIDQ_CNT_W'(f1_valid_ff) + midq_status.count)
                   >= b2y_pkg::MIDQ_CNT_W'(b2y_pkg::MIDQ_DEPTH);
   assign accept = push && !full;

   always_comb begin
      width_even  = {line_width[b2y_pkg::CSR_DATA_W-1:1], 1'b0};
      height_even = {frame_height[b2y_pkg::CSR_DATA_W-1:1], 1'b0};
      if (width_even < b2y_pkg::MIN_DIM) begin
         width_eff = b2y_pkg::MIN_DIM;
      end else if (width_even > b2y_pkg::WIDTH_LIMIT) begin
         width_eff = b2y_pkg::WIDTH_LIMIT;
      end else begin
         width_eff = width_even;
      end
      if (height_even < b2y_pkg::MIN_DIM) begin
         height_eff = b2y_pkg::MIN_DIM;
      end else if (height_even > b2y_pkg::HEIGHT_LIMIT) begin
         height_eff = b2y_pkg::HEIGHT_LIMIT;
      end else begin
         height_eff = height_even;
      end
   end

   // raster position advance, row steps on column wrap
   always_comb begin
      col_inc = {1'b0, col_ff} + 1'b1;
      row_inc = {1'b0, row_ff} + 1'b1;
      col_in  = col_ff;
      row_in  = row_ff;
      if (accept) begin
         if (b2y_pkg::CSR_DATA_W'(col_inc) >= width_eff) begin
            col_in = '0;
            if (b2y_pkg::CSR_DATA_W'(row_inc) >= height_eff) begin
               row_in = '0;
            end else begin
               row_in = row_inc[b2y_pkg::ROW_W-1:0];
            end
         end else begin
            col_in = col_inc[b2y_pkg::COL_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff      <= '0;
         row_ff      <= '0;
         left_ff     <= '0;
         f1_valid_ff <= 1'b0;
      end else begin
         col_ff      <= col_in;
         row_ff      <= row_in;
         f1_valid_ff <= accept;
         if (accept) begin
            left_ff <= req_word;
         end
      end
   end

   // line store: even rows write, odd rows read both upper neighbors
   always_ff @(posedge clock) begin
      if (accept) begin
         if (!row_ff[0]) begin
            store_mem[col_ff] <= req_word;
         end
         f1_ul_ff     <= store_mem[col_ff - 1'b1];
         f1_ur_ff     <= store_mem[col_ff];
         f1_pixel_ff  <= req_word;
         f1_left_ff   <= left_ff;
         f1_chroma_ff <= row_ff[0] && col_ff[0];
      end
   end

   assign midq_push              = f1_valid_ff;
   assign midq_entry.pixel       = f1_pixel_ff;
   assign midq_entry.left_pixel  = f1_left_ff;
   assign midq_entry.upper_left  = f1_ul_ff;
   assign midq_entry.upper_right = f1_ur_ff;
   assign midq_entry.chroma_en   = f1_chroma_ff;

   a_col_advance: assert property (@(posedge clock) disable iff (reset)
      accept |=> (col_ff == '0 || col_ff == $past(col_ff) + 1'b1))
      else $error("column counter skipped");

   a_chroma_class: assert property (@(posedge clock) disable iff (reset)
      (f1_valid_ff && f1_chroma_ff) |-> ($past(row_ff[0]) && $past(col_ff[0])))
      else $error("chroma flagged off an odd row and column");

endmodule

`default_nettype wire

// ----- src/b2y_midq.sv -----
`default_nettype none

module b2y_midq (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    push,
   input  wire b2y_pkg::midq_entry_type push_entry,
   input  wire logic                    pop,
   output b2y_pkg::midq_entry_type      head_entry,
   output b2y_pkg::midq_status_type     status
);

   b2y_pkg::midq_entry_type           slot_ff [b2y_pkg::MIDQ_DEPTH];
   logic [b2y_pkg::MIDQ_PTR_W-1:0]    wr_ptr_ff, rd_ptr_ff;
   logic [b2y_pkg::MIDQ_CNT_W-1:0]    count_ff;
   logic                              pop_fire;

   assign pop_fire = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + b2y_pkg::MIDQ_CNT_W'(push)
                     - b2y_pkg::MIDQ_CNT_W'(pop_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assign head_entry       = slot_ff[rd_ptr_ff];
   assign status.not_empty = (count_ff != '0);
   assign status.count     = count_ff;

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && count_ff == b2y_pkg::MIDQ_CNT_W'(b2y_pkg::MIDQ_DEPTH)))
      else $error("middle queue written while full");

endmodule

`default_nettype wire

// ----- src/b2y_back.sv -----
`default_nettype none

module b2y_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire b2y_pkg::midq_status_type midq_status,
   input  wire b2y_pkg::midq_entry_type  head_entry,
   output logic                          midq_pop,
   output logic                          empty,
   input  wire logic                     pop,
   output b2y_pkg::rsp_word_type         rsp_word
);

   function automatic logic [7:0] avg4(input logic [7:0] a, input logic [7:0] b,
                                       input logic [7:0] c, input logic [7:0] d);
      logic [9:0] sum;
      sum = 10'(a) + 10'(b) + 10'(c) + 10'(d) + 10'd2;
      return sum[9:2];
   endfunction

   function automatic logic [7:0] clamp_chroma(
      input logic signed [b2y_pkg::CHROMA_SUM_W-1:0] s);
      logic [7:0] res;
      if (s[b2y_pkg::CHROMA_SUM_W-1]) begin
         res = 8'd0;
      end else if (s[b2y_pkg::CHROMA_SUM_W-2]) begin
         res = 8'd255;
      end else begin
         res = s[b2y_pkg::CHROMA_SUM_W-3:b2y_pkg::FRAC_W];
      end
      return res;
   endfunction

   // stage 1: 2x2 averages and luma products
   logic                                     v1_ff, v2_ff, v3_ff;
   logic [7:0]                               avg_b_ff, avg_g_ff, avg_r_ff;
   logic [b2y_pkg::LUMA_SUM_W-1:0]           ly_b_ff, ly_g_ff, ly_r_ff;
   logic                                     ce1_ff, ce2_ff, ce3_ff;
   // stage 2: luma result and chroma products
   logic [7:0]                               luma2_ff, luma3_ff;
   logic signed [b2y_pkg::CHROMA_SUM_W-1:0]  cb_r_ff, cb_g_ff, cb_b_ff;
   logic signed [b2y_pkg::CHROMA_SUM_W-1:0]  cr_r_ff, cr_g_ff, cr_b_ff;
   // stage 3: chroma results
   logic [7:0]                               cb3_ff, cr3_ff;

   logic [b2y_pkg::LUMA_SUM_W-1:0]           luma_sum;
   logic signed [b2y_pkg::CHROMA_SUM_W-1:0]  cb_sum, cr_sum;

   b2y_pkg::rsp_word_type                    outq_ff [b2y_pkg::OUTQ_DEPTH];
   logic [b2y_pkg::OUTQ_PTR_W-1:0]           wr_ptr_ff, rd_ptr_ff;
   logic [b2y_pkg::OUTQ_CNT_W-1:0]           count_ff;
   logic [b2y_pkg::OUTQ_CNT_W:0]             in_flight;
   logic                                     pop_fire;
   b2y_pkg::rsp_word_type                    result;

   // only take a word when the output queue has a slot reserved for it
   assign in_flight = (b2y_pkg::OUTQ_CNT_W + 1)'(v1_ff) + (b2y_pkg::OUTQ_CNT_W + 1)'(v2_ff)
                    + (b2y_pkg::OUTQ_CNT_W + 1)'(v3_ff)
                    + (b2y_pkg::OUTQ_CNT_W + 1)'(count_ff);
   assign midq_pop  = midq_status.not_empty
                      && (in_flight < (b2y_pkg::OUTQ_CNT_W + 1)'(b2y_pkg::OUTQ_DEPTH));
   assign pop_fire  = pop && (count_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= midq_pop;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      avg_b_ff <= avg4(head_entry.pixel.blue, head_entry.left_pixel.blue,
                       head_entry.upper_left.blue, head_entry.upper_right.blue);
      avg_g_ff <= avg4(head_entry.pixel.green, head_entry.left_pixel.green,
                       head_entry.upper_left.green, head_entry.upper_right.green);
      avg_r_ff <= avg4(head_entry.pixel.red, head_entry.left_pixel.red,
                       head_entry.upper_left.red, head_entry.upper_right.red);
      ly_b_ff  <= b2y_pkg::LUMA_SUM_W'(head_entry.pixel.blue) * b2y_pkg::LUMA_B_COEF;
      ly_g_ff  <= b2y_pkg::LUMA_SUM_W'(head_entry.pixel.green) * b2y_pkg::LUMA_G_COEF;
      ly_r_ff  <= b2y_pkg::LUMA_SUM_W'(head_entry.pixel.red) * b2y_pkg::LUMA_R_COEF;
      ce1_ff   <= head_entry.chroma_en;

      luma2_ff <= luma_sum[b2y_pkg::LUMA_SUM_W-1:b2y_pkg::FRAC_W];
      cb_r_ff  <= $signed({1'b0, avg_r_ff}) * b2y_pkg::CB_R_COEF;
      cb_g_ff  <= $signed({1'b0, avg_g_ff}) * b2y_pkg::CB_G_COEF;
      cb_b_ff  <= $signed({1'b0, avg_b_ff}) * b2y_pkg::CB_B_COEF;
      cr_r_ff  <= $signed({1'b0, avg_r_ff}) * b2y_pkg::CR_R_COEF;
      cr_g_ff  <= $signed({1'b0, avg_g_ff}) * b2y_pkg::CR_G_COEF;
      cr_b_ff  <= $signed({1'b0, avg_b_ff}) * b2y_pkg::CR_B_COEF;
      ce2_ff   <= ce1_ff;

      luma3_ff <= luma2_ff;
      cb3_ff   <= clamp_chroma(cb_sum);
      cr3_ff   <= clamp_chroma(cr_sum);
      ce3_ff   <= ce2_ff;
   end

   // coefficients sum to just over 1.0, so the top byte never exceeds 255
   assign luma_sum = ly_b_ff + ly_g_ff + ly_r_ff;
   assign cb_sum   = cb_r_ff + cb_g_ff + cb_b_ff + b2y_pkg::CHROMA_OFFSET;
   assign cr_sum   = cr_r_ff + cr_g_ff + cr_b_ff + b2y_pkg::CHROMA_OFFSET;

   always_comb begin
      result.luma         = luma3_ff;
      result.chroma_valid = ce3_ff;
      result.cb           = ce3_ff ? cb3_ff : 8'd0;
      result.cr           = ce3_ff ? cr3_ff : 8'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (v3_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop_fire) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + b2y_pkg::OUTQ_CNT_W'(v3_ff)
                     - b2y_pkg::OUTQ_CNT_W'(pop_fire);
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff) begin
         outq_ff[wr_ptr_ff] <= result;
      end
   end

   assign empty    = (count_ff == '0);
   assign rsp_word = outq_ff[rd_ptr_ff];

   a_outq_room: assert property (@(posedge clock) disable iff (reset)
      !(v3_ff && count_ff == b2y_pkg::OUTQ_CNT_W'(b2y_pkg::OUTQ_DEPTH)))
      else $error("result queue written while full");

endmodule

`default_nettype wire

// ----- src/bgr_to_yuv420_subsampler.sv -----
`default_nettype none

// raster-order bgr pixels in, one word per pixel out carrying its luma; on odd rows at
// odd columns the word also carries cb/cr of the rounded 2x2 average (left pixel, this
// pixel and the two above from a 4096-entry line store), flagged by chroma_valid, with
// cb/cr zero otherwise. throughput is one pixel per clock while full is low; an accepted
// push passes the line store read stage, the middle queue, then three arithmetic stages
// (averages and luma products, luma sum and chroma products, chroma sums and clamping)
// ahead of an 8-word result queue. full rises when the middle queue plus the word in
// the read stage fill its depth; the result queue is credit-managed so the arithmetic
// stages never stall. the line store has no clearing pass and holds garbage until the
// first even row fills it. width and height are taken even (bit 0 ignored), clamped to
// 2..4096, and should only be written while the block is idle.

module bgr_to_yuv420_subsampler (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   output logic                                 full,
   input  wire b2y_pkg::req_word_type           req_word,
   output logic                                 empty,
   input  wire logic                            pop,
   output b2y_pkg::rsp_word_type                rsp_word,
   input  wire logic                            csr_write_en,
   input  wire logic [b2y_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [b2y_pkg::CSR_DATA_W-1:0]  csr_data
);

   logic [b2y_pkg::CSR_DATA_W-1:0] line_width_ff, frame_height_ff;

   logic                     midq_push, midq_pop;
   b2y_pkg::midq_entry_type  midq_in_entry, midq_head;
   b2y_pkg::midq_status_type midq_status;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         line_width_ff   <= b2y_pkg::LINE_WIDTH_RESET;
         frame_height_ff <= b2y_pkg::FRAME_HEIGHT_RESET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            b2y_pkg::CSR_LINE_WIDTH:   line_width_ff   <= csr_data;
            b2y_pkg::CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // front: position tracking, line store, classification
   b2y_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_word     (req_word),
      .line_width   (line_width_ff),
      .frame_height (frame_height_ff),
      .midq_status  (midq_status),
      .midq_push    (midq_push),
      .midq_entry   (midq_in_entry)
   );

   // decoupling queue between front and arithmetic
   b2y_midq u_midq (
      .clock      (clock),
      .reset      (reset),
      .push       (midq_push),
      .push_entry (midq_in_entry),
      .pop        (midq_pop),
      .head_entry (midq_head),
      .status     (midq_status)
   );

   // back: color math and result queue
   b2y_back u_back (
      .clock       (clock),
      .reset       (reset),
      .midq_status (midq_status),
      .head_entry  (midq_head),
      .midq_pop    (midq_pop),
      .empty       (empty),
      .pop         (pop),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

// ----- bench/bgr_to_yuv420_checker.sv -----
`timescale 1ns / 1ps

module bgr_to_yuv420_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            push,
   input  wire logic                            full,
   input  wire b2y_pkg::req_word_type           req_word,
   input  wire logic                            empty,
   input  wire logic                            pop,
   input  wire b2y_pkg::rsp_word_type           rsp_word,
   input  wire logic                            csr_write_en,
   input  wire logic [b2y_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [b2y_pkg::CSR_DATA_W-1:0]  csr_data,
   output int                                   mismatch_count,
   output int                                   words_pending
);

   localparam int Y_R = 9798;
   localparam int Y_G = 19235;
   localparam int Y_B = 3736;
   localparam int U_R = -5538;
   localparam int U_G = -10846;
   localparam int U_B = 16351;
   localparam int V_R = 16351;
   localparam int V_G = -13697;
   localparam int V_B = -2664;
   localparam int COEF_SHIFT  = 15;
   localparam int CHROMA_BIAS = 128;
   localparam int WIDTH_CAP   = b2y_pkg::MAX_LINE - b2y_pkg::MAX_LINE % 2;
   localparam logic [b2y_pkg::CSR_DATA_W-1:0] WIDTH_AT_RESET  = 13'd640;
   localparam logic [b2y_pkg::CSR_DATA_W-1:0] HEIGHT_AT_RESET = 13'd480;

   b2y_pkg::req_word_type          upper_row [b2y_pkg::MAX_LINE];
   b2y_pkg::req_word_type          left_pixel;
   int                             col_pos;
   int                             row_pos;
   logic [b2y_pkg::CSR_DATA_W-1:0] width_raw;
   logic [b2y_pkg::CSR_DATA_W-1:0] height_raw;
   b2y_pkg::rsp_word_type          yuv_queue [$];

   // bit 0 dropped, then held to 2..cap
   function automatic int even_clamped(logic [b2y_pkg::CSR_DATA_W-1:0] raw, int cap);
      int v;
      v = int'(raw) & ~1;
      if (v < 2) v = 2;
      if (v > cap) v = cap;
      return v;
   endfunction

   function automatic logic [7:0] saturate(int v);
      if (v < 0) return 8'd0;
      if (v > 255) return 8'd255;
      return 8'(v);
   endfunction

   function automatic int avg4(logic [7:0] a, logic [7:0] b, logic [7:0] c, logic [7:0] d);
      return (int'(a) + int'(b) + int'(c) + int'(d) + 2) >> 2;
   endfunction

   function automatic logic [7:0] chroma_value(int kr, int kg, int kb, int r, int g, int b);
      int s;
      s = kr * r + kg * g + kb * b + (CHROMA_BIAS << COEF_SHIFT);
      return saturate(s >>> COEF_SHIFT);
   endfunction

   function automatic b2y_pkg::rsp_word_type convert_pixel(b2y_pkg::req_word_type px);
      b2y_pkg::rsp_word_type yuv;
      b2y_pkg::req_word_type ul;
      b2y_pkg::req_word_type ur;
      int                    ar;
      int                    ag;
      int                    ab;
      yuv = '0;
      yuv.luma = saturate((Y_R * int'(px.red) + Y_G * int'(px.green)
                           + Y_B * int'(px.blue)) >>> COEF_SHIFT);
      if (row_pos % 2 == 0) begin
         upper_row[col_pos] = px;
      end else if (col_pos % 2 == 1) begin
         ul = upper_row[col_pos - 1];
         ur = upper_row[col_pos];
         ar = avg4(px.red, left_pixel.red, ul.red, ur.red);
         ag = avg4(px.green, left_pixel.green, ul.green, ur.green);
         ab = avg4(px.blue, left_pixel.blue, ul.blue, ur.blue);
         yuv.chroma_valid = 1'b1;
         yuv.cb = chroma_value(U_R, U_G, U_B, ar, ag, ab);
         yuv.cr = chroma_value(V_R, V_G, V_B, ar, ag, ab);
      end
      left_pixel = px;
      col_pos++;
      if (col_pos >= even_clamped(width_raw, WIDTH_CAP)) begin
         col_pos = 0;
         row_pos++;
         if (row_pos >= even_clamped(height_raw, b2y_pkg::HEIGHT_CAP)) row_pos = 0;
      end
      return yuv;
   endfunction

   task automatic check_field(string name, int want, int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      b2y_pkg::rsp_word_type want;
      if (reset) begin
         col_pos = 0;
         row_pos = 0;
         left_pixel = '0;
         width_raw = WIDTH_AT_RESET;
         height_raw = HEIGHT_AT_RESET;
         yuv_queue.delete();
         mismatch_count = 0;
      end else begin
         if (pop && !empty) begin
            if (yuv_queue.size() == 0) begin
               $display("%0t: word with none expected, expected none, actual %h",
                        $time, rsp_word);
               mismatch_count++;
            end else begin
               want = yuv_queue.pop_front();
               check_field("luma", want.luma, rsp_word.luma);
               check_field("chroma_valid", want.chroma_valid, rsp_word.chroma_valid);
               check_field("cb", want.cb, rsp_word.cb);
               check_field("cr", want.cr, rsp_word.cr);
            end
         end
         if (push && !full) yuv_queue.push_back(convert_pixel(req_word));
         if (csr_write_en) begin
            case (csr_index)
               b2y_pkg::CSR_LINE_WIDTH:   width_raw = csr_data;
               b2y_pkg::CSR_FRAME_HEIGHT: height_raw = csr_data;
               default: ;
            endcase
         end
      end
      words_pending = yuv_queue.size();
   end

endmodule

// ----- bench/bgr_to_yuv420_subsampler_tb.sv -----
`timescale 1ns / 1ps

module bgr_to_yuv420_subsampler_tb;

   localparam int CLOCK_PERIOD     = 20;
   localparam int RESET_CYCLES     = 8;
   localparam int RANDOM_ITEMS     = 1650;
   localparam int RECV_HOLD_CYCLES = 300;
   // a little margin after the last word drains before touching the registers
   localparam int SETTLE_CYCLES    = 10;
   localparam int WIDTH_CAP        = b2y_pkg::MAX_LINE - b2y_pkg::MAX_LINE % 2;
   localparam int OVERSIZE_ITEMS   = 40;
   // generous bound, well beyond the slowest run
   localparam int TIMEOUT_CYCLES   = 400_000;

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            push = 1'b0;
   logic                            full;
   b2y_pkg::req_word_type           req_word = '0;
   logic                            empty;
   logic                            pop = 1'b0;
   b2y_pkg::rsp_word_type           rsp_word;
   logic                            csr_write_en = 1'b0;
   logic [b2y_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [b2y_pkg::CSR_DATA_W-1:0]  csr_data = '0;

   int mismatch_count;
   int words_pending;

   // idling rates for each side, in percent of cycles
   int send_idle_pct = 0;
   int recv_idle_pct = 0;

   // receiver hold-off requests, served by the pop process
   int hold_asked = 0;
   int holds_served = 0;
   int hold_left = 0;

   // where the next pixel lands, kept only to steer the geometry changes
   int pos_col = 0;
   int pos_row = 0;
   int line_w = 640;
   int frame_h = 480;
   int items_sent = 0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   bgr_to_yuv420_subsampler u_top (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .full         (full),
      .req_word     (req_word),
      .empty        (empty),
      .pop          (pop),
      .rsp_word     (rsp_word),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_data     (csr_data)
   );

   bgr_to_yuv420_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .push           (push),
      .full           (full),
      .req_word       (req_word),
      .empty          (empty),
      .pop            (pop),
      .rsp_word       (rsp_word),
      .csr_write_en   (csr_write_en),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .mismatch_count (mismatch_count),
      .words_pending  (words_pending)
   );

   // receiver: random pop, or a long hold-off counted here when one is asked for
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_left > 0) begin
         pop <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (holds_served != hold_asked) begin
         holds_served <= hold_asked;
         hold_left <= RECV_HOLD_CYCLES;
         pop <= 1'b0;
      end else begin
         pop <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // width or height taken even and held to 2..cap
   function automatic int effective_size(logic [b2y_pkg::CSR_DATA_W-1:0] raw, int cap);
      int v;
      v = int'(raw) & ~1;
      if (v < 2) v = 2;
      if (v > cap) v = cap;
      return v;
   endfunction

   // opening sequence, packed as blue, green, red. two pixels at the reset
   // geometry, then 2x2: a landing pixel finishes row 0 at column 2 and wraps,
   // two pixels close a black/white block, then five blocks of four
   function automatic b2y_pkg::req_word_type opening_pixel(int k);
      if (k < 5) begin
         case (k)
            0, 4:    return 24'h000000;
            1, 3:    return 24'hFFFFFF;
            default: return 24'h808080;
         endcase
      end
      case ((k - 5) / 4)
         0: return 24'hFF0000;   // pure blue, cb at its top
         1: return 24'h0000FF;   // pure red, cr at its top
         2: return 24'h00FFFF;   // yellow, cb at its floor
         3: return 24'hFFFF00;   // cyan, cr at its floor
         default: begin
            // tiny values so the +2 rounding of the average shows
            case (k % 4)
               1:       return 24'h010203;
               2:       return 24'h000102;
               3:       return 24'h000001;
               default: return 24'h010000;
            endcase
         end
      endcase
   endfunction

   function automatic b2y_pkg::req_word_type random_pixel();
      b2y_pkg::req_word_type px;
      px = 24'($urandom);
      // pull channels to the rails now and then
      if ($urandom_range(7) == 0) px.blue = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(7) == 0) px.green = $urandom_range(1) ? 8'hFF : 8'h00;
      if ($urandom_range(7) == 0) px.red = $urandom_range(1) ? 8'hFF : 8'h00;
      return px;
   endfunction

   // mostly small lines, with out-of-range and oversize values mixed in
   function automatic logic [b2y_pkg::CSR_DATA_W-1:0] pick_width();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return b2y_pkg::CSR_DATA_W'($urandom_range(1));
      if (roll < 14) return b2y_pkg::CSR_DATA_W'($urandom_range(4095, 8191));
      if (roll < 75) return b2y_pkg::CSR_DATA_W'($urandom_range(2, 12));
      return b2y_pkg::CSR_DATA_W'($urandom_range(13, 70));
   endfunction

   function automatic logic [b2y_pkg::CSR_DATA_W-1:0] pick_height();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) return b2y_pkg::CSR_DATA_W'($urandom_range(1));
      if (roll < 16) return b2y_pkg::CSR_DATA_W'($urandom_range(4096, 8191));
      return b2y_pkg::CSR_DATA_W'($urandom_range(2, 10));
   endfunction

   // offer one word, with random idle cycles ahead of it; push stays high
   // after acceptance so back-to-back words go out without a gap
   task automatic send_pixel(input b2y_pkg::req_word_type px);
      while ($urandom_range(99) < send_idle_pct) begin
         push <= 1'b0;
         @(posedge clock);
      end
      push <= 1'b1;
      req_word <= px;
      do @(posedge clock); while (full);
      items_sent++;
      pos_col++;
      if (pos_col >= line_w) begin
         pos_col = 0;
         pos_row++;
         if (pos_row >= frame_h) pos_row = 0;
      end
   endtask

   task automatic stop_sending();
      push <= 1'b0;
      @(posedge clock);
   endtask

   // every pixel gives a word, so once none is owed the block is idle
   task automatic wait_for_results();
      do @(negedge clock); while (words_pending != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_geometry(input logic [b2y_pkg::CSR_DATA_W-1:0] width_raw,
                               input logic [b2y_pkg::CSR_DATA_W-1:0] height_raw);
      int pad;
      pad = 0;
      // leaving an odd row early is only safe if the new width lies at or below
      // the column; otherwise the rest of the row could reach line store
      // entries that no even row has written yet, so finish the row first
      if (pos_row % 2 == 1 && pos_col < effective_size(width_raw, WIDTH_CAP))
         pad = line_w - pos_col;
      if (pad > 0) begin
         repeat (pad) send_pixel(random_pixel());
         stop_sending();
      end
      wait_for_results();
      csr_write_en <= 1'b1;
      csr_index <= b2y_pkg::CSR_LINE_WIDTH;
      csr_data <= width_raw;
      @(posedge clock);
      csr_index <= b2y_pkg::CSR_FRAME_HEIGHT;
      csr_data <= height_raw;
      @(posedge clock);
      csr_write_en <= 1'b0;
      line_w = effective_size(width_raw, WIDTH_CAP);
      frame_h = effective_size(height_raw, b2y_pkg::HEIGHT_CAP);
   endtask

   initial begin
      int   k;
      int   regime;
      int   regime_end;
      int   burst;
      logic pressure_done;
      pressure_done = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed opening, with the sender idling lightly and the receiver a lot
      send_idle_pct <= 19;
      recv_idle_pct <= 69;
      for (k = 0; k < 2; k++) send_pixel(opening_pixel(k));
      stop_sending();
      set_geometry(13'd2, 13'd2);
      for (k = 2; k < 25; k++) send_pixel(opening_pixel(k));
      stop_sending();

      // random bursts, each behind a geometry change made while idle
      for (regime = 0; regime < 3; regime++) begin
         case (regime)
            0: begin
               send_idle_pct <= 19;
               recv_idle_pct <= 69;
            end
            1: begin
               send_idle_pct <= 69;
               recv_idle_pct <= 19;
            end
            default: begin
               send_idle_pct <= 0;
               recv_idle_pct <= 0;
            end
         endcase
         regime_end = items_sent + RANDOM_ITEMS / 3;
         while (items_sent < regime_end) begin
            set_geometry(pick_width(), pick_height());
            burst = $urandom_range(16, 64);
            if (!pressure_done) begin
               // receiver holds off while the sender keeps offering, so the
               // internal queues fill and full has to stall the input
               hold_asked <= hold_asked + 1;
               burst = 80;
               pressure_done = 1'b1;
            end
            repeat (burst) send_pixel(random_pixel());
            stop_sending();
         end
      end

      // oversize register values: a short run at the clamped geometry
      set_geometry(13'h1FFF, 13'h1FFF);
      repeat (OVERSIZE_ITEMS) send_pixel(random_pixel());
      stop_sending();
      wait_for_results();

      if (mismatch_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog
   initial begin
      #(TIMEOUT_CYCLES * CLOCK_PERIOD);
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
